@@ src/prxyz_pkg.sv @@
package prxyz_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TABLE_FRAC     = 14;
    localparam int INNER_W        = 42;
    localparam int GAIN_W         = 16;
    localparam int ANGLE_W        = 9;
    localparam int CFG_W          = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int OUT_W          = 24;

    // Every stage value stays below the sum of the magnitudes feeding it.
    localparam int VAL_W  = (COORD_BITS + 20 < INNER_W) ? COORD_BITS + 20 : INNER_W;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = VAL_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - TRIG_FRAC_BITS;
    localparam int Z0_W   = COORD_BITS + GAIN_W + 1;

    localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_X     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_Y     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_Z     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_GAIN = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 9'd90;
    localparam logic [ANGLE_W-1:0] HALF_TURN          = 9'd180;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 9'd270;
    localparam logic [ANGLE_W-1:0] FULL_TURN          = 9'd360;

    localparam int TBL_T_W = 16;
    localparam int TBL_DN  = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
    localparam int TBL_UP  = (TRIG_FRAC_BITS > TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
    localparam int TBL_RND = (1 << TBL_DN) >> 1;

    localparam logic signed [63:0] INNER_LIMIT = 64'sd2199023255551;
    localparam logic signed [63:0] OUT_MAX     = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN     = -64'sd8388608;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

    // Sine of 0 to 90 degrees in Q1.14.
    localparam int SINE_Q14 [91] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef logic signed [TRIG_W-1:0] t_trig_val;
    typedef logic signed [VAL_W-1:0]  t_val;

    typedef struct packed {
        t_trig_val cos_v;
        t_trig_val sin_v;
    } t_trig;

    function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W-1:0] d);
        return (d >= FULL_TURN) ? d - FULL_TURN : d;
    endfunction

    function automatic t_trig_val sine_of(input logic [ANGLE_W-1:0] deg);
        logic [6:0]         idx;
        logic               neg;
        logic [TBL_T_W-1:0] t;
        t_trig_val          mag;
        if (deg <= QUARTER_TURN) begin
            idx = deg[6:0];
            neg = 1'b0;
        end else if (deg <= HALF_TURN) begin
            idx = 7'(HALF_TURN - deg);
            neg = 1'b0;
        end else if (deg <= THREE_QUARTER_TURN) begin
            idx = 7'(deg - HALF_TURN);
            neg = 1'b1;
        end else begin
            idx = 7'(FULL_TURN - deg);
            neg = 1'b1;
        end
        t   = (TBL_T_W'(SINE_Q14[idx]) + TBL_T_W'(TBL_RND)) >> TBL_DN;
        mag = $signed(TRIG_W'(t) << TBL_UP);
        return neg ? -mag : mag;
    endfunction

    function automatic t_trig_val cos_of(input logic [ANGLE_W-1:0] deg);
        return sine_of(wrap_deg(ANGLE_W'(deg + QUARTER_TURN)));
    endfunction

    function automatic t_val sat_inner(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > INNER_LIMIT) begin
            r = INNER_LIMIT;
        end else if (v < -INNER_LIMIT) begin
            r = -INNER_LIMIT;
        end else begin
            r = v;
        end
        return t_val'(r);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX;
        end else if (v < OUT_MIN) begin
            r = OUT_MIN;
        end else begin
            r = v;
        end
        return OUT_W'(r);
    endfunction

endpackage

@@ src/prxyz_cfg.sv @@
module prxyz_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [prxyz_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [prxyz_pkg::CFG_W-1:0]           i_cfg_wdata,
    output prxyz_pkg::t_trig                      o_trig_x,
    output prxyz_pkg::t_trig                      o_trig_y,
    output prxyz_pkg::t_trig                      o_trig_z,
    output logic [prxyz_pkg::GAIN_W-1:0]          o_gain
);

    logic [prxyz_pkg::ANGLE_W-1:0] r_angle_x;
    logic [prxyz_pkg::ANGLE_W-1:0] r_angle_y;
    logic [prxyz_pkg::ANGLE_W-1:0] r_angle_z;
    logic [prxyz_pkg::GAIN_W-1:0]  r_gain;
    logic [prxyz_pkg::ANGLE_W-1:0] w_ax;
    logic [prxyz_pkg::ANGLE_W-1:0] w_ay;
    logic [prxyz_pkg::ANGLE_W-1:0] w_az;
    prxyz_pkg::t_trig              r_trig_x;
    prxyz_pkg::t_trig              r_trig_y;
    prxyz_pkg::t_trig              r_trig_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_x <= '0;
            r_angle_y <= '0;
            r_angle_z <= '0;
            r_gain    <= prxyz_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                prxyz_pkg::REG_ANGLE_X: begin
                    r_angle_x <= i_cfg_wdata[prxyz_pkg::ANGLE_W-1:0];
                end
                prxyz_pkg::REG_ANGLE_Y: begin
                    r_angle_y <= i_cfg_wdata[prxyz_pkg::ANGLE_W-1:0];
                end
                prxyz_pkg::REG_ANGLE_Z: begin
                    r_angle_z <= i_cfg_wdata[prxyz_pkg::ANGLE_W-1:0];
                end
                prxyz_pkg::REG_HEIGHT_GAIN: begin
                    r_gain <= i_cfg_wdata[prxyz_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ax = prxyz_pkg::wrap_deg(r_angle_x);
    assign w_ay = prxyz_pkg::wrap_deg(r_angle_y);
    assign w_az = prxyz_pkg::wrap_deg(r_angle_z);

    // The table lookups are registered; they change in the cycle after the angles do.
    always_ff @(posedge i_clk) begin
        r_trig_x.cos_v <= prxyz_pkg::cos_of(w_ax);
        r_trig_x.sin_v <= prxyz_pkg::sine_of(w_ax);
        r_trig_y.cos_v <= prxyz_pkg::cos_of(w_ay);
        r_trig_y.sin_v <= prxyz_pkg::sine_of(w_ay);
        r_trig_z.cos_v <= prxyz_pkg::cos_of(w_az);
        r_trig_z.sin_v <= prxyz_pkg::sine_of(w_az);
    end

    assign o_trig_x = r_trig_x;
    assign o_trig_y = r_trig_y;
    assign o_trig_z = r_trig_z;
    assign o_gain   = r_gain;

endmodule

@@ src/prxyz_rot.sv @@
module prxyz_rot (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  prxyz_pkg::t_val       i_a,
    input  prxyz_pkg::t_val       i_b,
    input  prxyz_pkg::t_val       i_pass,
    input  prxyz_pkg::t_trig      i_trig,
    output logic                  o_valid,
    input  logic                  i_ready,
    output prxyz_pkg::t_val       o_p,
    output prxyz_pkg::t_val       o_q,
    output prxyz_pkg::t_val       o_pass
);

    // o_p = a*cos + b*sin and o_q = b*cos - a*sin, each rounded to 8 fraction bits.

    logic                                  r_v1;
    logic signed [prxyz_pkg::PROD_W-1:0]   r_ac;
    logic signed [prxyz_pkg::PROD_W-1:0]   r_bs;
    logic signed [prxyz_pkg::PROD_W-1:0]   r_bc;
    logic signed [prxyz_pkg::PROD_W-1:0]   r_as;
    prxyz_pkg::t_val                       r_pass1;
    logic                                  r_v2;
    prxyz_pkg::t_val                       r_p;
    prxyz_pkg::t_val                       r_q;
    prxyz_pkg::t_val                       r_pass2;
    logic                                  w_rdy1;
    logic                                  w_rdy2;
    logic signed [prxyz_pkg::SUM_W-1:0]    w_sum_p;
    logic signed [prxyz_pkg::SUM_W-1:0]    w_sum_q;
    logic signed [prxyz_pkg::SHR_W-1:0]    w_shr_p;
    logic signed [prxyz_pkg::SHR_W-1:0]    w_shr_q;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_ac    <= $signed(i_a) * $signed(i_trig.cos_v);
            r_bs    <= $signed(i_b) * $signed(i_trig.sin_v);
            r_bc    <= $signed(i_b) * $signed(i_trig.cos_v);
            r_as    <= $signed(i_a) * $signed(i_trig.sin_v);
            r_pass1 <= i_pass;
        end
    end

    assign w_sum_p = prxyz_pkg::SUM_W'(r_ac) + prxyz_pkg::SUM_W'(r_bs) + prxyz_pkg::ROUND_HALF;
    assign w_sum_q = prxyz_pkg::SUM_W'(r_bc) - prxyz_pkg::SUM_W'(r_as) + prxyz_pkg::ROUND_HALF;
    assign w_shr_p = prxyz_pkg::SHR_W'(w_sum_p >>> prxyz_pkg::TRIG_FRAC_BITS);
    assign w_shr_q = prxyz_pkg::SHR_W'(w_sum_q >>> prxyz_pkg::TRIG_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_p     <= prxyz_pkg::sat_inner(64'(w_shr_p));
            r_q     <= prxyz_pkg::sat_inner(64'(w_shr_q));
            r_pass2 <= r_pass1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_pass  = r_pass2;

    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_rdy2) |=> (r_v1 && $stable(r_ac) && $stable(r_bc) && $stable(r_pass1)))
        else $error("product stage changed while stalled");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_ready) |=> (r_v2 && $stable(r_p) && $stable(r_q) && $stable(r_pass2)))
        else $error("sum stage changed while stalled");

endmodule

@@ src/point_rotation_xyz.sv @@
// Throughput: one point per clock while the output is not stalled; the chain of eight register stages
// (gain multiply, three rotations of two stages each, output clamp) is fully pipelined.
// Reset (synchronous, active low) empties the pipeline and sets angles to 0
// and the height gain to 1.0; the sine and cosine registers follow in the cycle after.
module point_rotation_xyz (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Fields from bit 0 up: in_x, in_y, in_z.
    input  logic [prxyz_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // Fields from bit 0 up: out_x, out_y, out_z.
    output logic [prxyz_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    input  logic                                   i_cfg_we,
    input  logic [prxyz_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [prxyz_pkg::CFG_W-1:0]            i_cfg_wdata
);

    localparam int C = prxyz_pkg::COORD_BITS;

    prxyz_pkg::t_trig                       w_trig_x;
    prxyz_pkg::t_trig                       w_trig_y;
    prxyz_pkg::t_trig                       w_trig_z;
    logic [prxyz_pkg::GAIN_W-1:0]           w_gain;
    logic signed [C-1:0]                    w_in_x;
    logic signed [C-1:0]                    w_in_y;
    logic signed [C-1:0]                    w_in_z;
    logic signed [prxyz_pkg::Z0_W-1:0]      w_zprod;
    logic                                   w_rdy_a;
    logic                                   r_va;
    prxyz_pkg::t_val                        r_x0;
    prxyz_pkg::t_val                        r_y0;
    prxyz_pkg::t_val                        r_z0;
    logic                                   w_rx_rdy;
    logic                                   w_rx_v;
    prxyz_pkg::t_val                        w_y1;
    prxyz_pkg::t_val                        w_z1;
    prxyz_pkg::t_val                        w_x0_d;
    logic                                   w_ry_rdy;
    logic                                   w_ry_v;
    prxyz_pkg::t_val                        w_x2;
    prxyz_pkg::t_val                        w_z2;
    prxyz_pkg::t_val                        w_y1_d;
    logic                                   w_rz_rdy;
    logic                                   w_rz_v;
    prxyz_pkg::t_val                        w_y3;
    prxyz_pkg::t_val                        w_x3;
    prxyz_pkg::t_val                        w_z2_d;
    logic                                   w_rdy_o;
    logic                                   r_vo;
    logic signed [prxyz_pkg::OUT_W-1:0]     r_out_x;
    logic signed [prxyz_pkg::OUT_W-1:0]     r_out_y;
    logic signed [prxyz_pkg::OUT_W-1:0]     r_out_z;

    prxyz_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_trig_x   (w_trig_x),
        .o_trig_y   (w_trig_y),
        .o_trig_z   (w_trig_z),
        .o_gain     (w_gain)
    );

    assign w_in_x  = i_s_axis_tdata[C-1:0];
    assign w_in_y  = i_s_axis_tdata[2*C-1:C];
    assign w_in_z  = i_s_axis_tdata[3*C-1:2*C];
    assign w_zprod = w_in_z * $signed({1'b0, w_gain});

    assign w_rdy_a         = !r_va || w_rx_rdy;
    assign o_s_axis_tready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_s_axis_tvalid) begin
            r_x0 <= prxyz_pkg::VAL_W'(w_in_x) <<< 8;
            r_y0 <= prxyz_pkg::VAL_W'(w_in_y) <<< 8;
            r_z0 <= prxyz_pkg::sat_inner(64'(w_zprod));
        end
    end

    prxyz_rot u_rot_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_va),
        .o_ready(w_rx_rdy),
        .i_a    (r_y0),
        .i_b    (r_z0),
        .i_pass (r_x0),
        .i_trig (w_trig_x),
        .o_valid(w_rx_v),
        .i_ready(w_ry_rdy),
        .o_p    (w_y1),
        .o_q    (w_z1),
        .o_pass (w_x0_d)
    );

    prxyz_rot u_rot_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_rx_v),
        .o_ready(w_ry_rdy),
        .i_a    (w_x0_d),
        .i_b    (w_z1),
        .i_pass (w_y1),
        .i_trig (w_trig_y),
        .o_valid(w_ry_v),
        .i_ready(w_rz_rdy),
        .o_p    (w_x2),
        .o_q    (w_z2),
        .o_pass (w_y1_d)
    );

    // With a = y1 and b = x2 the pair gives y3 on o_p and x3 on o_q.
    prxyz_rot u_rot_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_ry_v),
        .o_ready(w_rz_rdy),
        .i_a    (w_y1_d),
        .i_b    (w_x2),
        .i_pass (w_z2),
        .i_trig (w_trig_z),
        .o_valid(w_rz_v),
        .i_ready(w_rdy_o),
        .o_p    (w_y3),
        .o_q    (w_x3),
        .o_pass (w_z2_d)
    );

    assign w_rdy_o = !r_vo || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_rdy_o) begin
            r_vo <= w_rz_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o && w_rz_v) begin
            r_out_x <= prxyz_pkg::sat_out(64'(w_x3));
            r_out_y <= prxyz_pkg::sat_out(64'(w_y3));
            r_out_z <= prxyz_pkg::sat_out(64'(w_z2_d));
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = prxyz_pkg::OUT_DATA_W'({r_out_z, r_out_y, r_out_x});

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_entry_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_va |-> o_s_axis_tready)
        else $error("input refused while entry stage is empty");

endmodule

@@ verif/point_rotation_xyz_tb.sv @@
`timescale 1ns / 100ps

module point_rotation_xyz_tb;
    localparam int COORD_BITS     = prxyz_pkg::COORD_BITS;
    localparam int TRIG_FRAC_BITS = prxyz_pkg::TRIG_FRAC_BITS;
    localparam int OUT_W          = prxyz_pkg::OUT_W;
    localparam int CFG_W          = prxyz_pkg::CFG_W;
    localparam int CFG_ADDR_W     = prxyz_pkg::CFG_ADDR_W;
    localparam int IN_DATA_W      = prxyz_pkg::IN_DATA_W;
    localparam int OUT_DATA_W     = prxyz_pkg::OUT_DATA_W;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PAUSE_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_POINTS = 85;

    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;
    localparam int DEG_270 = 270;
    localparam int DEG_360 = 360;

    localparam longint INNER_MAX = 64'sd2199023255551;
    localparam longint Q_MAX     = 64'sd8388607;
    localparam longint Q_MIN     = -64'sd8388608;

    localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam int SIN_TABLE [91] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_coord;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_rot_point;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int unsigned ang_x   = 0;
    int unsigned ang_y   = 0;
    int unsigned ang_z   = 0;
    int          gain_q8 = 256;

    t_coord     points_in[$];
    t_rot_point rotated_points[$];
    t_coord     src_point;
    t_rot_point want;

    int errors        = 0;
    int checked       = 0;
    int saturated     = 0;
    int settings      = 1;
    int src_gap       = 0;
    int sink_gap      = 0;
    int hold_left     = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cycle_cnt     = 0;
    bit hold_req      = 1'b0;
    bit quiet_tail    = 1'b0;

    point_rotation_xyz u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned wrap_angle(int unsigned d);
        d = d & 32'h1FF;
        return (d >= DEG_360) ? d - DEG_360 : d;
    endfunction

    function automatic longint sin_deg(int unsigned d);
        if (d <= DEG_90) begin
            return SIN_TABLE[d];
        end else if (d <= DEG_180) begin
            return SIN_TABLE[DEG_180 - d];
        end else if (d <= DEG_270) begin
            return -SIN_TABLE[d - DEG_180];
        end
        return -SIN_TABLE[DEG_360 - d];
    endfunction

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mac_round(longint a, longint c, longint b, longint s);
        longint t;
        t = a * c + b * s + (longint'(1) <<< (TRIG_FRAC_BITS - 1));
        return clamp64(t >>> TRIG_FRAC_BITS, -INNER_MAX, INNER_MAX);
    endfunction

    function automatic t_rot_point rotate_point(t_coord p);
        int unsigned ax, ay, az;
        longint sx, cx, sy, cy, sz, cz;
        longint x0, y0, z0, y1, z1, x2, z2, x3, y3;
        t_rot_point r;
        ax = wrap_angle(ang_x);
        ay = wrap_angle(ang_y);
        az = wrap_angle(ang_z);
        sx = sin_deg(ax);
        cx = sin_deg(wrap_angle(ax + DEG_90));
        sy = sin_deg(ay);
        cy = sin_deg(wrap_angle(ay + DEG_90));
        sz = sin_deg(az);
        cz = sin_deg(wrap_angle(az + DEG_90));
        x0 = longint'(p.x) * 256;
        y0 = longint'(p.y) * 256;
        z0 = clamp64(longint'(p.z) * gain_q8, -INNER_MAX, INNER_MAX);
        y1 = mac_round(y0, cx, z0, sx);
        z1 = mac_round(z0, cx, y0, -sx);
        x2 = mac_round(x0, cy, z1, sy);
        z2 = mac_round(z1, cy, x0, -sy);
        x3 = mac_round(x2, cz, y1, -sz);
        y3 = mac_round(x2, sz, y1, cz);
        r.x = OUT_W'(clamp64(x3, Q_MIN, Q_MAX));
        r.y = OUT_W'(clamp64(y3, Q_MIN, Q_MAX));
        r.z = OUT_W'(clamp64(z2, Q_MIN, Q_MAX));
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return COORD_BITS'($urandom());
        end else if (sel < 7) begin
            return COORD_BITS'(int'($urandom_range(0, 600)) - 300);
        end else if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return C_MAX;
                1: return C_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return COORD_BITS'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic int unsigned rand_angle_word();
        int unsigned a;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            a = $urandom_range(0, 359);
        end else if (sel < 17) begin
            a = $urandom_range(360, 511);
        end else begin
            a = DEG_90 * $urandom_range(0, 3);
        end
        // Bits above the angle field must be dropped by the block.
        if ($urandom_range(0, 3) == 0) begin
            a = a | ($urandom_range(0, 127) << 9);
        end
        return a;
    endfunction

    function automatic int unsigned rand_gain_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return $urandom_range(0, 65535);
        end else if (sel < 6) begin
            return 256;
        end else if (sel < 8) begin
            return $urandom_range(0, 1024);
        end else if (sel == 8) begin
            return 0;
        end
        return 65535;
    endfunction

    task automatic push_point(input int px, input int py, input int pz);
        t_coord c;
        c.x = COORD_BITS'(px);
        c.y = COORD_BITS'(py);
        c.z = COORD_BITS'(pz);
        points_in.push_back(c);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
        end while (points_in.size() != 0 || s_tvalid || rotated_points.size() != 0);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input int unsigned wx, input int unsigned wy,
                            input int unsigned wz, input int unsigned wg);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= prxyz_pkg::REG_ANGLE_X;
        cfg_wdata <= CFG_W'(wx);
        @(posedge clk);
        cfg_addr  <= prxyz_pkg::REG_ANGLE_Y;
        cfg_wdata <= CFG_W'(wy);
        @(posedge clk);
        cfg_addr  <= prxyz_pkg::REG_ANGLE_Z;
        cfg_wdata <= CFG_W'(wz);
        @(posedge clk);
        cfg_addr  <= prxyz_pkg::REG_HEIGHT_GAIN;
        cfg_wdata <= CFG_W'(wg);
        @(posedge clk);
        cfg_we  <= 1'b0;
        ang_x   = wx & 32'h1FF;
        ang_y   = wy & 32'h1FF;
        ang_z   = wz & 32'h1FF;
        gain_q8 = wg & 32'hFFFF;
        settings++;
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                src_point.x = s_tdata[COORD_BITS-1:0];
                src_point.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
                src_point.z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
                rotated_points.push_back(rotate_point(src_point));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (points_in.size() != 0) begin
                    src_point = points_in.pop_front();
                    s_tdata   <= IN_DATA_W'({src_point.z, src_point.y, src_point.x});
                    s_tvalid  <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rotated_points.size() == 0) begin
                    $error("Rotated point with none outstanding: tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = rotated_points.pop_front();
                    checked++;
                    if (m_tdata[OUT_W-1:0] !== want.x) begin
                        $error("out_x mismatch: expected %0d, got %0d",
                               want.x, $signed(m_tdata[OUT_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[2*OUT_W-1:OUT_W] !== want.y) begin
                        $error("out_y mismatch: expected %0d, got %0d",
                               want.y, $signed(m_tdata[2*OUT_W-1:OUT_W]));
                        errors++;
                    end
                    if (m_tdata[3*OUT_W-1:2*OUT_W] !== want.z) begin
                        $error("out_z mismatch: expected %0d, got %0d",
                               want.z, $signed(m_tdata[3*OUT_W-1:2*OUT_W]));
                        errors++;
                    end
                    if (want.x == SAT_HI || want.x == SAT_LO || want.y == SAT_HI
                        || want.y == SAT_LO || want.z == SAT_HI || want.z == SAT_LO) begin
                        saturated++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
                    sink_gap = $urandom_range(1, 17);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();
        src_idle_pct  = 20;
        sink_idle_pct = 20;

        // Register values straight out of reset.
        push_point(0, 0, 0);
        push_point(C_MAX, C_MAX, C_MAX);
        push_point(C_MIN, C_MIN, C_MIN);
        push_point(1, -1, -1);
        push_point(16'h5555, 16'shAAAA, 16'h5555);

        // Full gain drives the outputs into saturation in both directions.
        set_regs(45, 30, 60, 65535);
        push_point(C_MAX, C_MIN, C_MAX);
        push_point(C_MIN, C_MAX, C_MIN);
        push_point(-1, 1, -1);
        push_point(100, -200, 300);

        set_regs(DEG_90, DEG_180, DEG_270, 0);
        push_point(12345, -12345, C_MAX);
        push_point(C_MIN, C_MAX, -1);

        // Angles at and past a full turn, with junk above the angle field.
        set_regs(359, 16'hFE00 | DEG_360, 511, 1);
        push_point(C_MAX, C_MAX, C_MIN);
        push_point(-5, 7, -9);
        push_point(0, C_MIN, C_MAX);

        set_regs(DEG_180, DEG_90, 0, 65535);
        push_point(C_MIN, C_MIN, C_MIN);
        push_point(C_MAX, 0, 0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                1: set_regs(359, 359, 359, 65535);
                2: set_regs(511, 511, 511, 0);
                default: set_regs(rand_angle_word(), rand_angle_word(),
                                  rand_angle_word(), rand_gain_word());
            endcase
            src_idle_pct  = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
            sink_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
            if (ph == 3) begin
                src_idle_pct = 0;
                hold_req     = 1'b1;
            end
            if (ph == RAND_PHASES - 1) begin
                quiet_tail = 1'b1;
            end
            repeat (PHASE_POINTS) push_point(rand_coord(), rand_coord(), rand_coord());
        end

        wait_drained();
        $display("Checked %0d rotated points over %0d angle and gain settings,",
                 checked, settings);
        $display("including wrapped angles, zero and full gain; %0d hit output saturation.",
                 saturated);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
